// ----- design/rcc_pkg.sv -----
// ----------------------------------------------------------------------------
// rcc_pkg
// Shared types, register indexes and constants of the rotating cylinder
// contact core: request codes, rotation gain and the per-step angle table.
// ----------------------------------------------------------------------------
package rcc_pkg;

    // configuration port
    localparam int REG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [REG_IDX_W-1:0] REG_AXIS_X     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_AXIS_Y     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BASE_Z     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_CYL_LENGTH = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CYL_RADIUS = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_TURN_RATE  = 3'd5;

    // request codes
    localparam logic REQ_QUERY = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    // rotation unit
    localparam int CORDIC_STEPS_DEF = 24;
    localparam logic [31:0] CORDIC_GAIN = 32'h9B74EDA8;
    localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

    typedef logic signed [31:0] fix32_t;
    typedef logic [30:0] ulen_t;

    // rotation angle per step, fraction of a turn in 2^-32 units
    localparam logic [29:0] ATAN_TURN [32] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331, 30'd21354465, 30'd10679838, 30'd5340245,
        30'd2670163, 30'd1335087, 30'd667544, 30'd333772,
        30'd166886, 30'd83443, 30'd41722, 30'd20861,
        30'd10430, 30'd5215, 30'd2608, 30'd1304,
        30'd652, 30'd326, 30'd163, 30'd81,
        30'd41, 30'd20, 30'd10, 30'd5,
        30'd3, 30'd1, 30'd1, 30'd0
    };

    function automatic logic signed [33:0] atan_turn(input logic [4:0] idx);
        return $signed({4'b0000, ATAN_TURN[idx]});
    endfunction

endpackage

// ----- design/rcc_if.sv -----
// ----------------------------------------------------------------------------
// rcc_if
// Valid/ready channels of the rotating cylinder contact core: request items
// in and contact results out.
// ----------------------------------------------------------------------------
interface rcc_item_if;
    import rcc_pkg::*;

    logic   valid;
    logic   ready;
    logic   req_type;
    fix32_t pos_x;
    fix32_t pos_y;
    fix32_t pos_z;
    ulen_t  reach_radius;
    ulen_t  body_radius;
    logic [31:0] time_step;

    modport source (
        output valid, req_type, pos_x, pos_y, pos_z, reach_radius, body_radius,
        time_step,
        input  ready
    );
    modport sink (
        input  valid, req_type, pos_x, pos_y, pos_z, reach_radius, body_radius,
        time_step,
        output ready
    );
endinterface

interface rcc_result_if;
    import rcc_pkg::*;

    logic   valid;
    logic   ready;
    logic   contact_found;
    fix32_t gap_distance;
    fix32_t normal_x;
    fix32_t normal_y;
    fix32_t overlap;
    fix32_t contact_x;
    fix32_t contact_y;
    fix32_t contact_z;

    modport source (
        output valid, contact_found, gap_distance, normal_x, normal_y, overlap,
        contact_x, contact_y, contact_z,
        input  ready
    );
    modport sink (
        input  valid, contact_found, gap_distance, normal_x, normal_y, overlap,
        contact_x, contact_y, contact_z,
        output ready
    );
endinterface

// ----- design/rcc_mul.sv -----
// ----------------------------------------------------------------------------
// rcc_mul
// Shared unsigned magnitude multiplier with a registered product; the
// sequencer handles signs and rounding around it.
// ----------------------------------------------------------------------------
module rcc_mul (
    input  logic        clk,
    input  logic [33:0] op_a,
    input  logic [33:0] op_b,
    output logic [67:0] prod_reg
);
    // one product per cycle, ready the cycle after the operands
    always_ff @(posedge clk)
    begin
        prod_reg <= 68'(op_a) * 68'(op_b);
    end
endmodule

// ----- design/rotating_cylinder_contact_core.sv -----
// ----------------------------------------------------------------------------
// rotating_cylinder_contact_core
// Particle contact against a vertical rotating cylinder, fixed point.
// ----------------------------------------------------------------------------
// A tick item gives no result. A query with contact runs the 32-step square
// root, two 31-step restoring divisions (skipped when the distance is zero)
// and the rotation steps. The square root and the divisions share one
// shift/subtract datapath, and every product comes from one shared
// multiplier. The block takes one item at a time; a finished result sits in
// the output register while the next item is taken.
module rotating_cylinder_contact_core #(
    parameter int CORDIC_STEPS = rcc_pkg::CORDIC_STEPS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [rcc_pkg::REG_IDX_W-1:0]   wr_index,
    input  logic [rcc_pkg::CFG_DATA_W-1:0]  wr_data,
    rcc_item_if.sink                        item,
    rcc_result_if.source                    result
);
    import rcc_pkg::*;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_TICK_M = 5'd1;
    localparam logic [4:0] S_TICK_W = 5'd2;
    localparam logic [4:0] S_SQX    = 5'd3;
    localparam logic [4:0] S_SQY    = 5'd4;
    localparam logic [4:0] S_SQL    = 5'd5;
    localparam logic [4:0] S_CMP    = 5'd6;
    localparam logic [4:0] S_SQRT   = 5'd7;
    localparam logic [4:0] S_RHO    = 5'd8;
    localparam logic [4:0] S_DIVX   = 5'd9;
    localparam logic [4:0] S_UX     = 5'd10;
    localparam logic [4:0] S_DIVY   = 5'd11;
    localparam logic [4:0] S_UY     = 5'd12;
    localparam logic [4:0] S_ROT    = 5'd13;
    localparam logic [4:0] S_GX     = 5'd14;
    localparam logic [4:0] S_GY     = 5'd15;
    localparam logic [4:0] S_GW     = 5'd16;
    localparam logic [4:0] S_CORD   = 5'd17;
    localparam logic [4:0] S_CLMP   = 5'd18;
    localparam logic [4:0] S_LX     = 5'd19;
    localparam logic [4:0] S_LY     = 5'd20;
    localparam logic [4:0] S_LW     = 5'd21;
    localparam logic [4:0] S_DONE   = 5'd22;

    localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);

    function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
        if (v > 38'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (v < -38'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    function automatic logic signed [33:0] sat_q30(input logic signed [33:0] v);
        if (v > ONE_Q30)
            return ONE_Q30;
        else if (v < -ONE_Q30)
            return -ONE_Q30;
        else
            return v;
    endfunction

    // configuration and kept state
    fix32_t      axis_x_reg, axis_y_reg, base_z_reg, turn_rate_reg;
    ulen_t       cyl_length_reg, cyl_radius_reg;
    logic [31:0] spin_reg;

    // sequencer and datapath
    logic [4:0]         state_reg;
    logic [4:0]         cnt_reg;
    fix32_t             px_reg, py_reg, pz_reg;
    ulen_t              body_reg;
    logic [31:0]        time_reg;
    logic signed [32:0] dx_reg, dy_reg;
    logic [31:0]        lim_reg;
    logic               zok_reg;
    logic               found_reg;
    logic [65:0]        sq_reg;
    logic [63:0]        acc_reg, aux_reg;
    logic [30:0]        quot_reg;
    logic [32:0]        rho_reg;
    fix32_t             ux_reg, uy_reg;
    logic signed [33:0] cx_reg, cy_reg, cz_reg;
    fix32_t             ptx_reg, pty_reg;

    // output register
    logic   out_valid_reg;
    logic   out_found_reg;
    fix32_t out_gap_reg, out_nx_reg, out_ny_reg, out_over_reg;
    fix32_t out_cx_reg, out_cy_reg, out_cz_reg;

    // combinational values
    logic               accept;
    logic               load_out;
    logic [32:0]        dx_mag, dy_mag;
    logic [31:0]        tr_mag, ux_mag, uy_mag;
    logic [33:0]        cx_mag, cy_mag, lev_mag;
    logic signed [34:0] lev;
    logic signed [33:0] gap;
    logic signed [34:0] over;
    logic [33:0]        mul_a, mul_b;
    logic [67:0]        mul_p;
    logic [67:0]        tick_prod;
    logic [67:0]        rnd32, rnd31;
    logic [30:0]        r32;
    logic [36:0]        r31;
    logic signed [37:0] lever_term;
    logic signed [37:0] pos_term;
    logic               lever_neg;
    logic [63:0]        sqrt_bit;
    logic [64:0]        sub_a, sub_b;
    logic [65:0]        sub_d;
    logic               sub_ge;
    logic [30:0]        quot_sat;
    logic [31:0]        spin_plus;
    logic [1:0]         quarter;
    logic [31:0]        resid;
    logic signed [33:0] xs, ys, step_atan;
    logic signed [33:0] z_hi, z_lo;
    logic signed [33:0] pz_in;

    assign accept   = item.valid && item.ready;
    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || result.ready);

    // magnitudes for the multiplier
    assign dx_mag  = dx_reg[32] ? 33'(-dx_reg) : 33'(dx_reg);
    assign dy_mag  = dy_reg[32] ? 33'(-dy_reg) : 33'(dy_reg);
    assign tr_mag  = turn_rate_reg[31] ? 32'(-turn_rate_reg) : 32'(turn_rate_reg);
    assign ux_mag  = ux_reg[31] ? 32'(-ux_reg) : 32'(ux_reg);
    assign uy_mag  = uy_reg[31] ? 32'(-uy_reg) : 32'(uy_reg);
    assign cx_mag  = cx_reg[33] ? 34'(-cx_reg) : 34'(cx_reg);
    assign cy_mag  = cy_reg[33] ? 34'(-cy_reg) : 34'(cy_reg);
    assign lev     = $signed({4'b0000, body_reg}) + $signed({2'b00, rho_reg})
                   - $signed({4'b0000, cyl_radius_reg});
    assign lev_mag = lev[34] ? 34'(-lev) : lev[33:0];
    assign gap     = $signed({1'b0, rho_reg}) - $signed({3'b000, cyl_radius_reg});
    assign over    = $signed({4'b0000, body_reg}) - 35'(gap);

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_TICK_M:
            begin
                mul_a = {2'b00, tr_mag};
                mul_b = {2'b00, time_reg};
            end
            S_SQX:
            begin
                mul_a = {1'b0, dx_mag};
                mul_b = {1'b0, dx_mag};
            end
            S_SQY:
            begin
                mul_a = {1'b0, dy_mag};
                mul_b = {1'b0, dy_mag};
            end
            S_SQL:
            begin
                mul_a = {2'b00, lim_reg};
                mul_b = {2'b00, lim_reg};
            end
            S_GX:
            begin
                mul_a = {2'b00, ux_mag};
                mul_b = {2'b00, CORDIC_GAIN};
            end
            S_GY:
            begin
                mul_a = {2'b00, uy_mag};
                mul_b = {2'b00, CORDIC_GAIN};
            end
            S_LX:
            begin
                mul_a = lev_mag;
                mul_b = cx_mag;
            end
            S_LY:
            begin
                mul_a = lev_mag;
                mul_b = cy_mag;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    rcc_mul u_mul (
        .clk      (clk),
        .op_a     (mul_a),
        .op_b     (mul_b),
        .prod_reg (mul_p)
    );

    // product post-processing: tick sign, rounding for gain and lever
    assign tick_prod = turn_rate_reg[31] ? 68'(-mul_p) : mul_p;
    assign rnd32     = mul_p + 68'h0_8000_0000;
    assign r32       = rnd32[62:32];
    assign rnd31     = mul_p + 68'h0_4000_0000;
    assign r31       = rnd31[67:31];
    assign lever_neg = (state_reg == S_LY) ? (lev[34] ^ cx_reg[33])
                                           : (lev[34] ^ cy_reg[33]);
    assign lever_term = lever_neg ? -$signed({1'b0, r31}) : $signed({1'b0, r31});
    assign pos_term   = (state_reg == S_LY) ? 38'(px_reg) : 38'(py_reg);

    // shared shift/subtract unit for square root and division
    assign sqrt_bit = 64'(1) << {cnt_reg, 1'b0};
    always_comb
    begin
        sub_a = {1'b0, acc_reg};
        if (state_reg == S_SQRT)
            sub_b = {1'b0, aux_reg} + {1'b0, sqrt_bit};
        else
            sub_b = {1'b0, aux_reg};
    end
    assign sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ge = !sub_d[65];
    assign quot_sat = (quot_reg > 31'd1073741824) ? 31'd1073741824 : quot_reg;

    // quarter-turn reduction and rotation step terms
    assign spin_plus = spin_reg + 32'h2000_0000;
    assign quarter   = spin_plus[31:30];
    assign resid     = spin_reg - {quarter, 30'd0};
    assign xs        = cx_reg >>> cnt_reg;
    assign ys        = cy_reg >>> cnt_reg;
    assign step_atan = atan_turn(cnt_reg);

    // height band at accept
    assign pz_in = 34'(item.pos_z);
    assign z_hi  = 34'(base_z_reg) + $signed({3'b000, cyl_length_reg})
                 + $signed({3'b000, item.reach_radius});
    assign z_lo  = 34'(base_z_reg) - $signed({3'b000, item.reach_radius});

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_x_reg     <= '0;
            axis_y_reg     <= '0;
            base_z_reg     <= '0;
            cyl_length_reg <= 31'd65536;
            cyl_radius_reg <= 31'd65536;
            turn_rate_reg  <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_AXIS_X:     axis_x_reg     <= wr_data;
                REG_AXIS_Y:     axis_y_reg     <= wr_data;
                REG_BASE_Z:     base_z_reg     <= wr_data;
                REG_CYL_LENGTH: cyl_length_reg <= wr_data[30:0];
                REG_CYL_RADIUS: cyl_radius_reg <= wr_data[30:0];
                REG_TURN_RATE:  turn_rate_reg  <= wr_data;
                default:        ;
            endcase
        end
    end

    // sequencer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            spin_reg  <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                        state_reg <= (item.req_type == REQ_TICK) ? S_TICK_M : S_SQX;
                end
                S_TICK_M: state_reg <= S_TICK_W;
                S_TICK_W:
                begin
                    spin_reg  <= spin_reg + tick_prod[39:8];
                    state_reg <= S_IDLE;
                end
                S_SQX:    state_reg <= S_SQY;
                S_SQY:    state_reg <= S_SQL;
                S_SQL:    state_reg <= S_CMP;
                S_CMP:
                begin
                    if (!zok_reg || (sq_reg > mul_p[65:0]))
                    begin
                        found_reg <= 1'b0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        found_reg <= 1'b1;
                        cnt_reg   <= 5'd31;
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    if (cnt_reg == 5'd0)
                        state_reg <= S_RHO;
                    else
                        cnt_reg <= cnt_reg - 5'd1;
                end
                S_RHO:
                begin
                    cnt_reg   <= 5'd30;
                    state_reg <= (aux_reg == 64'd0) ? S_ROT : S_DIVX;
                end
                S_DIVX:
                begin
                    if (cnt_reg == 5'd0)
                        state_reg <= S_UX;
                    else
                        cnt_reg <= cnt_reg - 5'd1;
                end
                S_UX:
                begin
                    cnt_reg   <= 5'd30;
                    state_reg <= S_DIVY;
                end
                S_DIVY:
                begin
                    if (cnt_reg == 5'd0)
                        state_reg <= S_UY;
                    else
                        cnt_reg <= cnt_reg - 5'd1;
                end
                S_UY:     state_reg <= S_ROT;
                S_ROT:    state_reg <= S_GX;
                S_GX:     state_reg <= S_GY;
                S_GY:     state_reg <= S_GW;
                S_GW:
                begin
                    cnt_reg   <= 5'd0;
                    state_reg <= S_CORD;
                end
                S_CORD:
                begin
                    if (cnt_reg == LAST_STEP)
                        state_reg <= S_CLMP;
                    else
                        cnt_reg <= cnt_reg + 5'd1;
                end
                S_CLMP:   state_reg <= S_LX;
                S_LX:     state_reg <= S_LY;
                S_LY:     state_reg <= S_LW;
                S_LW:     state_reg <= S_DONE;
                S_DONE:
                begin
                    if (load_out)
                        state_reg <= S_IDLE;
                end
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    px_reg   <= item.pos_x;
                    py_reg   <= item.pos_y;
                    pz_reg   <= item.pos_z;
                    body_reg <= item.body_radius;
                    time_reg <= item.time_step;
                    dx_reg   <= 33'(item.pos_x) - 33'(axis_x_reg);
                    dy_reg   <= 33'(item.pos_y) - 33'(axis_y_reg);
                    lim_reg  <= {1'b0, cyl_radius_reg} + {1'b0, item.reach_radius};
                    zok_reg  <= !(pz_in > z_hi) && !(pz_in < z_lo);
                end
            end
            S_SQY:
            begin
                sq_reg <= mul_p[65:0];
            end
            S_SQL:
            begin
                sq_reg <= sq_reg + mul_p[65:0];
            end
            S_CMP:
            begin
                acc_reg <= sq_reg[63:0];
                aux_reg <= '0;
            end
            S_SQRT:
            begin
                if (sub_ge)
                begin
                    acc_reg <= sub_d[63:0];
                    aux_reg <= (aux_reg >> 1) + sqrt_bit;
                end
                else
                begin
                    aux_reg <= aux_reg >> 1;
                end
            end
            S_RHO:
            begin
                rho_reg <= aux_reg[32:0];
                if (aux_reg == 64'd0)
                begin
                    ux_reg <= 32'sd1073741824;
                    uy_reg <= '0;
                end
                else
                begin
                    acc_reg <= 64'({dx_mag, 30'd0});
                    aux_reg <= {aux_reg[33:0], 30'd0};
                end
            end
            S_DIVX, S_DIVY:
            begin
                if (sub_ge)
                    acc_reg <= sub_d[63:0];
                aux_reg  <= aux_reg >> 1;
                quot_reg <= {quot_reg[29:0], sub_ge};
            end
            S_UX:
            begin
                ux_reg  <= dx_reg[32] ? -$signed({1'b0, quot_sat})
                                      : $signed({1'b0, quot_sat});
                acc_reg <= 64'({dy_mag, 30'd0});
                aux_reg <= 64'({rho_reg, 30'd0});
            end
            S_UY:
            begin
                uy_reg <= dy_reg[32] ? -$signed({1'b0, quot_sat})
                                     : $signed({1'b0, quot_sat});
            end
            S_ROT:
            begin
                case (quarter)
                    2'd1:
                    begin
                        ux_reg <= -uy_reg;
                        uy_reg <= ux_reg;
                    end
                    2'd2:
                    begin
                        ux_reg <= -ux_reg;
                        uy_reg <= -uy_reg;
                    end
                    2'd3:
                    begin
                        ux_reg <= uy_reg;
                        uy_reg <= -ux_reg;
                    end
                    default:
                    begin
                        ux_reg <= ux_reg;
                        uy_reg <= uy_reg;
                    end
                endcase
                cz_reg <= 34'($signed(resid));
            end
            S_GY:
            begin
                cx_reg <= ux_reg[31] ? -$signed({3'b000, r32}) : $signed({3'b000, r32});
            end
            S_GW:
            begin
                cy_reg <= uy_reg[31] ? -$signed({3'b000, r32}) : $signed({3'b000, r32});
            end
            S_CORD:
            begin
                if (!cz_reg[33])
                begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    cz_reg <= cz_reg - step_atan;
                end
                else
                begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    cz_reg <= cz_reg + step_atan;
                end
            end
            S_CLMP:
            begin
                cx_reg <= sat_q30(cx_reg);
                cy_reg <= sat_q30(cy_reg);
            end
            S_LY:
            begin
                ptx_reg <= sat32(pos_term - lever_term);
            end
            S_LW:
            begin
                pty_reg <= sat32(pos_term - lever_term);
            end
            default:
            begin
            end
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_found_reg <= found_reg;
            out_gap_reg   <= found_reg ? gap[31:0] : '0;
            out_nx_reg    <= found_reg ? cx_reg[31:0] : '0;
            out_ny_reg    <= found_reg ? cy_reg[31:0] : '0;
            out_over_reg  <= found_reg ? sat32(38'(over)) : '0;
            out_cx_reg    <= found_reg ? ptx_reg : '0;
            out_cy_reg    <= found_reg ? pty_reg : '0;
            out_cz_reg    <= found_reg ? pz_reg : '0;
        end
    end

    assign item.ready           = (state_reg == S_IDLE);
    assign result.valid         = out_valid_reg;
    assign result.contact_found = out_found_reg;
    assign result.gap_distance  = out_gap_reg;
    assign result.normal_x      = out_nx_reg;
    assign result.normal_y      = out_ny_reg;
    assign result.overlap       = out_over_reg;
    assign result.contact_x     = out_cx_reg;
    assign result.contact_y     = out_cy_reg;
    assign result.contact_z     = out_cz_reg;

`ifndef SYNTHESIS
    // a finished item always lands in the output register
    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |=> result.valid)
        else $error("finished item did not reach the output register");

    // a miss carries all-zero fields; gap, overlap, normal_x and contact_z are checked
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.contact_found) |->
        (result.gap_distance == 32'd0 && result.overlap == 32'd0 &&
         result.normal_x == 32'd0 && result.contact_z == 32'd0))
        else $error("no-contact result with nonzero fields");

    // normals stay inside the unit range
    a_normal_range: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.contact_found) |->
        ($signed(result.normal_x) <= 32'sd1073741824 &&
         $signed(result.normal_x) >= -32'sd1073741824 &&
         $signed(result.normal_y) <= 32'sd1073741824 &&
         $signed(result.normal_y) >= -32'sd1073741824))
        else $error("contact normal out of range");
`endif

endmodule
